// ===== rtl/core/lry_pkg.sv =====
// ----------------------------------------------------------------------------
// lry_pkg
// Shared types, conversion weights and the channel clamp.
// ----------------------------------------------------------------------------
package lry_pkg;

    localparam int ChanW = 8;
    localparam int PixW  = 32;
    localparam int FwdW  = 26;
    localparam int InvW  = 28;
    localparam int FracW = 16;

    typedef logic [ChanW-1:0]        t_chan;
    typedef logic signed [ChanW:0]   t_chroma;
    typedef logic signed [FwdW-1:0]  t_fwd_sum;
    typedef logic signed [InvW-1:0]  t_inv_sum;

    localparam t_fwd_sum KYR  = 26'sd19595;
    localparam t_fwd_sum KYG  = 26'sd38470;
    localparam t_fwd_sum KYB  = 26'sd7471;
    localparam t_fwd_sum KCBR = 26'sd11058;
    localparam t_fwd_sum KCBG = 26'sd21710;
    localparam t_fwd_sum KHALF = 26'sd32768;
    localparam t_fwd_sum KCRG = 26'sd27439;
    localparam t_fwd_sum KCRB = 26'sd5329;

    localparam t_inv_sum KRCR = 28'sd91881;
    localparam t_inv_sum KGCB = 28'sd22554;
    localparam t_inv_sum KGCR = 28'sd46802;
    localparam t_inv_sum KBCB = 28'sd116130;

    localparam logic [0:0] CMD_LOAD  = 1'b0;
    localparam logic [0:0] CMD_PIXEL = 1'b1;

    // Floor shift by 16 and clamp to the channel range.
    function automatic t_chan clamp_chan(input t_inv_sum v);
        logic signed [InvW-FracW-1:0] s;
        t_chan                        res;
        s = v[InvW-1:FracW];
        if (s < 0) begin
            res = '0;
        end else if (s > 12'sd255) begin
            res = '1;
        end else begin
            res = s[ChanW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/lry_if.sv =====
// ----------------------------------------------------------------------------
// lry_if
// Stream channels for the input words and the result words.
// ----------------------------------------------------------------------------
interface lry_in_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] pixel_in;
    logic [7:0]  table_index;
    logic [7:0]  table_value;
    logic        last_in;

    modport source (output valid, cmd, pixel_in, table_index, table_value, last_in,
                    input ready);
    modport sink   (input valid, cmd, pixel_in, table_index, table_value, last_in,
                    output ready);
endinterface

interface lry_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_out;
    logic        last_out;

    modport source (output valid, pixel_out, last_out, input ready);
    modport sink   (input valid, pixel_out, last_out, output ready);
endinterface

// ===== rtl/core/lry_inv.sv =====
// ----------------------------------------------------------------------------
// lry_inv
// Inverse YCbCr to RGB transform in two stages: weighted sums, then clamp.
// ----------------------------------------------------------------------------
module lry_inv
    import lry_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  t_chan        i_y,
    input  t_chroma      i_cb,
    input  t_chroma      i_cr,
    input  t_chan        i_alpha,
    input  logic         i_last,
    output logic         o_valid,
    output logic [31:0]  o_pixel,
    output logic         o_last
);

    t_inv_sum   n_rs, n_gs, n_bs;
    t_inv_sum   y_ext, cb_ext, cr_ext;
    t_inv_sum   r_rs, r_gs, r_bs;
    t_chan      r_alpha3;
    logic       r_last3;
    logic       r_v3;
    logic       r_v4;
    logic [31:0] r_pixel;
    logic       r_last4;

    always_comb begin
        y_ext  = $signed({4'b0, i_y, 16'b0});
        cb_ext = InvW'(i_cb);
        cr_ext = InvW'(i_cr);
        n_rs   = y_ext + cr_ext * KRCR;
        n_gs   = y_ext - cb_ext * KGCB - cr_ext * KGCR;
        n_bs   = y_ext + cb_ext * KBCB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rs     <= n_rs;
            r_gs     <= n_gs;
            r_bs     <= n_bs;
            r_alpha3 <= i_alpha;
            r_last3  <= i_last;
            r_pixel  <= {r_alpha3, clamp_chan(r_bs), clamp_chan(r_gs), clamp_chan(r_rs)};
            r_last4  <= r_last3;
        end
    end

    assign o_valid = r_v4;
    assign o_pixel = r_pixel;
    assign o_last  = r_last4;

endmodule

// ===== rtl/core/luma_remap_ycbcr_pixel.sv =====
// ----------------------------------------------------------------------------
// luma_remap_ycbcr_pixel
// Takes one word per clock: a pixel word is converted to YCbCr, its luma is
// replaced from a 256-entry table and it is converted back to clamped RGB
// with alpha kept; a table word writes one entry and gives no result. A pixel
// leaves through the forward-sum, table-lookup, inverse-sum and clamp
// registers in that order, and the pipeline sustains one word per cycle. The
// whole pipeline holds while a result is not taken. A table write is seen by
// every pixel accepted after it; table entries hold no value until written.
// ----------------------------------------------------------------------------
module luma_remap_ycbcr_pixel
    import lry_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    lry_in_if.sink     i_pix,
    lry_out_if.source  o_pix
);

    logic       en;
    t_chan      r_in, g_in, b_in;
    t_fwd_sum   n_ys, n_cbs, n_crs;

    logic       r_v1;
    logic       r_cmd1;
    t_fwd_sum   r_ys, r_cbs, r_crs;
    t_chan      r_alpha1;
    logic       r_last1;
    t_chan      r_idx1;
    t_chan      r_val1;

    logic       r_v2;
    t_chan      r_y;
    t_chroma    r_cb2, r_cr2;
    t_chan      r_alpha2;
    logic       r_last2;

    t_chan      r_luma [256];

    logic       inv_valid;

    assign en          = !inv_valid || o_pix.ready;
    assign i_pix.ready = en;

    always_comb begin
        r_in  = i_pix.pixel_in[7:0];
        g_in  = i_pix.pixel_in[15:8];
        b_in  = i_pix.pixel_in[23:16];
        n_ys  = FwdW'(r_in) * KYR + FwdW'(g_in) * KYG + FwdW'(b_in) * KYB;
        n_cbs = FwdW'(b_in) * KHALF - FwdW'(r_in) * KCBR - FwdW'(g_in) * KCBG;
        n_crs = FwdW'(r_in) * KHALF - FwdW'(g_in) * KCRG - FwdW'(b_in) * KCRB;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_pix.valid;
            r_v2 <= r_v1 && (r_cmd1 == CMD_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd1   <= i_pix.cmd;
            r_ys     <= n_ys;
            r_cbs    <= n_cbs;
            r_crs    <= n_crs;
            r_alpha1 <= i_pix.pixel_in[31:24];
            r_last1  <= i_pix.last_in;
            r_idx1   <= i_pix.table_index;
            r_val1   <= i_pix.table_value;
            r_cb2    <= r_cbs[FwdW-2:FracW];
            r_cr2    <= r_crs[FwdW-2:FracW];
            r_alpha2 <= r_alpha1;
            r_last2  <= r_last1;
        end
    end

    // Writes and reads share the second stage, so table order follows word order.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_v1 && (r_cmd1 == CMD_LOAD)) begin
                r_luma[r_idx1] <= r_val1;
            end
            r_y <= r_luma[r_ys[FracW+ChanW-1:FracW]];
        end
    end

    lry_inv u_inv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v2),
        .i_y     (r_y),
        .i_cb    (r_cb2),
        .i_cr    (r_cr2),
        .i_alpha (r_alpha2),
        .i_last  (r_last2),
        .o_valid (inv_valid),
        .o_pixel (o_pix.pixel_out),
        .o_last  (o_pix.last_out)
    );

    assign o_pix.valid = inv_valid;

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_v1 && (r_cmd1 == CMD_LOAD) |=> !r_v2)
        else $error("table word produced a result");

    a_pixel_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_v1 && (r_cmd1 == CMD_PIXEL) |=> r_v2)
        else $error("pixel word lost between stages");

    a_stall_holds_luma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en && r_v2 |=> r_v2 && $stable(r_y))
        else $error("luma lookup changed during stall");

endmodule
